// ===== rtl/core/aes256_pkg.sv =====
// ----------------------------------------------------------------------------
// aes256_pkg
// shared constants, s-box tables and round functions for the aes-256 engine
// ----------------------------------------------------------------------------
`default_nettype none

package aes256_pkg;

    localparam int CfgIdxW    = 3;
    localparam int NumRounds  = 14;
    localparam int RkEntries  = 30;
    localparam int RkAddrW    = 5;
    localparam int RoundW     = 4;

    localparam logic [CfgIdxW-1:0] CfgKey0 = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgKey1 = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgKey2 = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgKey3 = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgMode = 3'd4;

    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_block;

    function automatic t_byte xtime(input t_byte a);
        xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    endfunction

    function automatic t_byte gmul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte p;
        acc = 8'h00;
        p   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ p;
            p = xtime(p);
        end
        gmul = acc;
    endfunction

    function automatic t_byte gpow_inv(input t_byte x);
        // x^254 through a fixed addition chain
        t_byte x2, x3, x6, x12, x15, x30, x60, x120, x126, x127, x254;
        x2   = gmul(x, x);
        x3   = gmul(x2, x);
        x6   = gmul(x3, x3);
        x12  = gmul(x6, x6);
        x15  = gmul(x12, x3);
        x30  = gmul(x15, x15);
        x60  = gmul(x30, x30);
        x120 = gmul(x60, x60);
        x126 = gmul(x120, x6);
        x127 = gmul(x126, x);
        x254 = gmul(x127, x127);
        gpow_inv = x254;
    endfunction

    function automatic t_byte affine(input t_byte v);
        affine = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                 ^ {v[3:0], v[7:4]} ^ 8'h63;
    endfunction

    // constant 256-entry tables built at elaboration
    function automatic logic [2047:0] build_fwd();
        logic [2047:0] t;
        t = '0;
        for (int i = 0; i < 256; i++) t[i*8 +: 8] = affine(gpow_inv(t_byte'(i)));
        build_fwd = t;
    endfunction

    function automatic logic [2047:0] build_inv();
        logic [2047:0] t;
        t_byte s;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            s = affine(gpow_inv(t_byte'(i)));
            t[s*8 +: 8] = t_byte'(i);
        end
        build_inv = t;
    endfunction

    localparam logic [2047:0] FwdBox = build_fwd();
    localparam logic [2047:0] InvBox = build_inv();

    function automatic t_byte sbox(input t_byte a);
        sbox = FwdBox[a*8 +: 8];
    endfunction

    function automatic t_byte isbox(input t_byte a);
        isbox = InvBox[a*8 +: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // byte n of the block sits at bits 127-8n
    function automatic t_byte bget(input t_block s, input int n);
        bget = s[127-8*n -: 8];
    endfunction

    function automatic t_block fwd_round(input t_block s, input logic last);
        t_block t;
        t_block m;
        t_byte c0, c1, c2, c3;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r+4*c) -: 8] = sbox(bget(s, r + 4*((c + r) & 3)));
        for (int c = 0; c < 4; c++) begin
            c0 = bget(t, 4*c); c1 = bget(t, 4*c+1);
            c2 = bget(t, 4*c+2); c3 = bget(t, 4*c+3);
            m[127-8*(4*c)   -: 8] = xtime(c0) ^ xtime(c1) ^ c1 ^ c2 ^ c3;
            m[127-8*(4*c+1) -: 8] = c0 ^ xtime(c1) ^ xtime(c2) ^ c2 ^ c3;
            m[127-8*(4*c+2) -: 8] = c0 ^ c1 ^ xtime(c2) ^ xtime(c3) ^ c3;
            m[127-8*(4*c+3) -: 8] = xtime(c0) ^ c0 ^ c1 ^ c2 ^ xtime(c3);
        end
        fwd_round = last ? t : m;
    endfunction

    function automatic t_block inv_sub_shift(input t_block s);
        t_block t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r+4*((c + r) & 3)) -: 8] = isbox(bget(s, r + 4*c));
        inv_sub_shift = t;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block m;
        t_byte c0, c1, c2, c3;
        for (int c = 0; c < 4; c++) begin
            c0 = bget(s, 4*c); c1 = bget(s, 4*c+1);
            c2 = bget(s, 4*c+2); c3 = bget(s, 4*c+3);
            m[127-8*(4*c)   -: 8] = gmul(c0, 8'h0e) ^ gmul(c1, 8'h0b)
                                    ^ gmul(c2, 8'h0d) ^ gmul(c3, 8'h09);
            m[127-8*(4*c+1) -: 8] = gmul(c0, 8'h09) ^ gmul(c1, 8'h0e)
                                    ^ gmul(c2, 8'h0b) ^ gmul(c3, 8'h0d);
            m[127-8*(4*c+2) -: 8] = gmul(c0, 8'h0d) ^ gmul(c1, 8'h09)
                                    ^ gmul(c2, 8'h0e) ^ gmul(c3, 8'h0b);
            m[127-8*(4*c+3) -: 8] = gmul(c0, 8'h0b) ^ gmul(c1, 8'h0d)
                                    ^ gmul(c2, 8'h09) ^ gmul(c3, 8'h0e);
        end
        inv_mix = m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aes256_keyexp.sv =====
// ----------------------------------------------------------------------------
// aes256_keyexp
// key schedule sequencer: two 32-bit words per cycle into the key memory
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_keyexp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [255:0]                i_key,
    output logic                             o_busy,
    output logic                             o_wr_en,
    output logic [aes256_pkg::RkAddrW-1:0]   o_wr_addr,
    output logic [63:0]                      o_wr_data
);
    import aes256_pkg::*;

    // window of the last eight schedule words, oldest first
    logic [255:0]          r_win, n_win;
    logic [RkAddrW-1:0]    r_addr, n_addr;
    logic                  r_busy, n_busy;
    t_byte                 r_rc, n_rc;
    logic [31:0]           w_even, w_odd, t_even, t_odd;

    // entry a holds words 2a and 2a+1: the even word starts a rotated group,
    // a plain sub group or needs no substitution
    always_comb begin
        unique case (r_addr[1:0])
            2'b00:   t_even = sub_word({r_win[23:0], r_win[31:24]}) ^ {r_rc, 24'h0};
            2'b10:   t_even = sub_word(r_win[31:0]);
            default: t_even = r_win[31:0];
        endcase
        w_even = r_win[255:224] ^ t_even;
        t_odd  = w_even;
        w_odd  = r_win[223:192] ^ t_odd;
    end

    always_comb begin
        n_win  = r_win;
        n_addr = r_addr;
        n_busy = r_busy;
        n_rc   = r_rc;
        o_wr_en   = 1'b0;
        o_wr_data = r_win[255:192];
        if (i_start) begin
            n_win  = i_key;
            n_addr = '0;
            n_busy = 1'b1;
            n_rc   = 8'h01;
        end else if (r_busy) begin
            o_wr_en = 1'b1;
            n_addr  = r_addr + 1'b1;
            if (r_addr < RkAddrW'(4)) begin
                // raw key words go out first
                o_wr_data = r_win[255 - 64*r_addr[1:0] -: 64];
            end else begin
                o_wr_data = {w_even, w_odd};
                n_win     = {r_win[191:0], w_even, w_odd};
                if (r_addr[1:0] == 2'b00) n_rc = xtime(r_rc);
                if (r_addr == RkAddrW'(RkEntries - 1)) n_busy = 1'b0;
            end
        end
    end

    assign o_wr_addr = r_addr;
    assign o_busy    = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_addr <= '0;
        end else begin
            r_busy <= n_busy;
            r_addr <= n_addr;
        end
        r_win <= n_win;
        r_rc  <= n_rc;
    end

endmodule

`default_nettype wire

// ===== rtl/core/aes256_block_cipher.sv =====
// ----------------------------------------------------------------------------
// aes256_block_cipher
// aes-256 ecb engine with round keys held in a synchronous memory
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | to core   | i_valid / o_ready  | i_block_hi, i_block_lo
// out     | from core | o_valid / i_ready  | o_result_hi, o_result_lo
// cfg     | to core   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// a block reads two entries per round key, for the initial key addition and
// each of the 14 rounds, as a 128-bit key is two reads of the 64-bit memory,
// then loads the output word in the done state and returns to idle
// the first block after reset or a key write first waits for key expansion
// reset is synchronous, active low; round keys are not cleared
// the output word has its own register: a new block may start while it waits,
// and a finished block holds in the done state until that register is free
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_block_cipher (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [aes256_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [63:0]                   i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [63:0]                   i_block_hi,
    input  wire logic [63:0]                   i_block_lo,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [63:0]                        o_result_hi,
    output logic [63:0]                        o_result_lo
);
    import aes256_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_KEYS = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // configuration registers
    logic [255:0]       r_key;
    logic               r_mode;
    logic               r_keys_ready;

    t_state             r_state, n_state;
    logic [RoundW-1:0]  r_round, n_round;
    t_block             r_work, n_work;
    logic               r_mode_lat;

    // round-key memory, two 64-bit entries per round key
    logic [63:0]        mem_rk [RkEntries];
    logic [63:0]        r_rk_rd;
    logic [RkAddrW-1:0] rd_addr;
    logic [63:0]        r_rk_hi;
    logic               r_half;

    logic               ke_start, ke_busy, ke_we;
    logic [RkAddrW-1:0] ke_addr;
    logic [63:0]        ke_data;

    logic               r_out_valid;
    t_block             r_out;

    logic               in_acc;
    logic               done_go;
    t_block             rk_full;
    logic [RoundW-1:0]  key_idx;
    logic [RoundW-1:0]  fetch_round;

    aes256_keyexp u_keyexp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ke_start),
        .i_key     (r_key),
        .o_busy    (ke_busy),
        .o_wr_en   (ke_we),
        .o_wr_addr (ke_addr),
        .o_wr_data (ke_data)
    );

    // ready whenever idle; a waiting result sits in the output register
    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign ke_start = in_acc && !r_keys_ready;
    // finished block moves to the output register once it is free or draining
    assign done_go  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    function automatic logic [RoundW-1:0] i_block_mode_key();
        i_block_mode_key = r_mode ? '0 : RoundW'(NumRounds);
    endfunction

    // the lo half of a round key is read while r_half is low,
    // the hi half of the next round's key while it is high
    assign fetch_round = (r_state == S_RUN && r_half && r_round != RoundW'(NumRounds))
                         ? r_round + 1'b1 : r_round;

    always_comb begin
        if (r_state == S_IDLE) key_idx = i_block_mode_key();
        else key_idx = r_mode_lat ? fetch_round : RoundW'(NumRounds) - fetch_round;
    end

    assign rd_addr = {key_idx, (r_state == S_RUN) && !r_half};

    always_ff @(posedge i_clk) begin
        if (ke_we) mem_rk[ke_addr] <= ke_data;
        r_rk_rd <= mem_rk[rd_addr];
    end

    assign rk_full = {r_rk_hi, r_rk_rd};

    // round sequence: each round reads two entries, hi then lo; r_half toggles
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_work  = r_work;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_work  = {i_block_hi, i_block_lo};
                    n_round = '0;
                    n_state = r_keys_ready ? S_RUN : S_KEYS;
                end
            end
            S_KEYS: begin
                if (!ke_busy && !ke_start) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_half) begin
                    if (r_round == '0) n_work = r_work ^ rk_full;
                    else if (r_mode_lat)
                        n_work = fwd_round(r_work, r_round == RoundW'(NumRounds)) ^ rk_full;
                    else if (r_round == RoundW'(NumRounds))
                        n_work = inv_sub_shift(r_work) ^ rk_full;
                    else
                        n_work = inv_mix(inv_sub_shift(r_work) ^ rk_full);
                    if (r_round == RoundW'(NumRounds)) n_state = S_DONE;
                    else n_round = r_round + 1'b1;
                end
            end
            S_DONE: begin
                if (done_go) begin
                    n_state = S_IDLE;
                    n_round = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_round      <= '0;
            r_half       <= 1'b0;
            r_key        <= '0;
            r_mode       <= 1'b1;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode_lat   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            // half-select steps only while reading keys for a round
            if (r_state == S_RUN) r_half <= !r_half;
            else r_half <= 1'b0;
            if (in_acc) r_mode_lat <= r_mode;
            if (ke_start) r_keys_ready <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgKey0: begin r_key[255:192] <= i_cfg_data; r_keys_ready <= 1'b0; end
                    CfgKey1: begin r_key[191:128] <= i_cfg_data; r_keys_ready <= 1'b0; end
                    CfgKey2: begin r_key[127:64]  <= i_cfg_data; r_keys_ready <= 1'b0; end
                    CfgKey3: begin r_key[63:0]    <= i_cfg_data; r_keys_ready <= 1'b0; end
                    CfgMode: r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (done_go) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
        r_work <= n_work;
        if (!r_half) r_rk_hi <= r_rk_rd;
        if (done_go) r_out <= r_work;
    end

    assign o_valid     = r_out_valid;
    assign o_result_hi = r_out[127:64];
    assign o_result_lo = r_out[63:0];

endmodule

`default_nettype wire

// ===== rtl/core/aes256_checker.sv =====
// ----------------------------------------------------------------------------
// aes256_checker
// port-level checks on the cipher engine
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [63:0] o_result_hi
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_hi))
        else $error("result dropped while stalled");

    a_no_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second block taken while busy");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> ##1 !$rose(o_valid))
        else $error("result appeared too soon");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind aes256_block_cipher aes256_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_result_hi (o_result_hi)
);

`default_nettype wire
